[hw/rtl/thop_pkg.sv]
package thop_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [5:0] FIXED_BYTES = 6'd20;

  localparam logic [3:0] FID_SRCPORT = 4'd0;
  localparam logic [3:0] FID_DSTPORT = 4'd1;
  localparam logic [3:0] FID_SEQ     = 4'd2;
  localparam logic [3:0] FID_ACK     = 4'd3;
  localparam logic [3:0] FID_HDRLEN  = 4'd4;
  localparam logic [3:0] FID_FLAGS   = 4'd5;
  localparam logic [3:0] FID_WINDOW  = 4'd6;
  localparam logic [3:0] FID_CKSUM   = 4'd7;
  localparam logic [3:0] FID_URGENT  = 4'd8;
  localparam logic [3:0] FID_OPTKIND = 4'd9;
  localparam logic [3:0] FID_OPTLEN  = 4'd10;
  localparam logic [3:0] FID_OPTBYTE = 4'd11;
  localparam logic [3:0] FID_STATUS  = 4'd12;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OFFSET    = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_KIND  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_OVERRUN   = 3'd5;

  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_WSCALE  = 8'd3;
  localparam logic [7:0] KIND_SACK    = 8'd5;
  localparam logic [7:0] KIND_TSTAMP  = 8'd8;

  localparam logic [3:0] MIN_OFFSET = 4'd5;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic        last;
    logic [2:0]  status;
    logic [5:0]  option_number;
    logic [31:0] field_value;
    logic [3:0]  field_id;
  } rec_t;

  typedef struct packed {
    logic two;
    rec_t r1;
    rec_t r0;
  } pair_t;

  function automatic logic [7:0] min_option_len(input logic [7:0] kind);
    logic [7:0] len;
    case (kind)
      KIND_MSS:    len = 8'd4;
      KIND_WSCALE: len = 8'd3;
      KIND_TSTAMP: len = 8'd10;
      default:     len = 8'd2;
    endcase
    return len;
  endfunction

  function automatic rec_t make_rec(input logic [3:0] id, input logic [31:0] value,
                                    input logic [5:0] optnum, input logic [2:0] st,
                                    input logic lst);
    rec_t r;
    r.field_id      = id;
    r.field_value   = value;
    r.option_number = optnum;
    r.status        = st;
    r.last          = lst;
    return r;
  endfunction

endpackage

[hw/rtl/thop_step.sv]
module thop_step #(
  parameter int MAX_OPTION_DATA = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       data_byte,
  input  logic             first,
  output logic             emit,
  output thop_pkg::pair_t  pair
);
  import thop_pkg::*;

  localparam logic [7:0] LEN_LIMIT = 8'(MAX_OPTION_DATA + 2);

  logic        active, active_next;
  logic [5:0]  byte_position, byte_position_next;
  logic [5:0]  header_bytes, header_bytes_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  phase_t      option_phase, option_phase_next;
  logic [7:0]  option_kind_held, option_kind_held_next;
  logic [5:0]  option_bytes_left, option_bytes_left_next;
  logic [5:0]  option_count, option_count_next;

  logic        b_active;
  logic [5:0]  b_pos, b_hdr, b_left, b_count;
  logic [31:0] b_acc, acc;
  phase_t      b_phase;
  logic [7:0]  b_kind;
  logic [2:0]  err;
  logic [6:0]  pos_inc;
  logic [5:0]  cnt_inc;

  always_comb begin
    active_next            = active;
    byte_position_next     = byte_position;
    header_bytes_next      = header_bytes;
    field_accumulator_next = field_accumulator;
    option_phase_next      = option_phase;
    option_kind_held_next  = option_kind_held;
    option_bytes_left_next = option_bytes_left;
    option_count_next      = option_count;
    emit    = 1'b0;
    pair    = '0;
    err     = ST_OK;
    b_active = first ? 1'b1 : active;
    b_pos    = first ? 6'd0 : byte_position;
    b_hdr    = first ? 6'd0 : header_bytes;
    b_acc    = first ? 32'd0 : field_accumulator;
    b_phase  = first ? PH_KIND : option_phase;
    b_kind   = first ? 8'd0 : option_kind_held;
    b_left   = first ? 6'd0 : option_bytes_left;
    b_count  = first ? 6'd0 : option_count;
    acc      = {b_acc[23:0], data_byte};
    pos_inc  = {1'b0, b_pos} + 7'd1;
    cnt_inc  = b_count + 6'd1;

    if (go && b_active) begin
      active_next            = 1'b1;
      byte_position_next     = b_pos;
      header_bytes_next      = b_hdr;
      field_accumulator_next = b_acc;
      option_phase_next      = b_phase;
      option_kind_held_next  = b_kind;
      option_bytes_left_next = b_left;
      option_count_next      = b_count;

      if (b_pos < FIXED_BYTES) begin
        field_accumulator_next = acc;
        byte_position_next     = pos_inc[5:0];
        case (b_pos)
          6'd1, 6'd3, 6'd7, 6'd11, 6'd13, 6'd15, 6'd17, 6'd19: begin
            emit = 1'b1;
            field_accumulator_next = '0;
            case (b_pos)
              6'd1:  pair.r0 = make_rec(FID_SRCPORT, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
              6'd3:  pair.r0 = make_rec(FID_DSTPORT, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
              6'd7:  pair.r0 = make_rec(FID_SEQ, acc, '0, ST_OK, 1'b0);
              6'd11: pair.r0 = make_rec(FID_ACK, acc, '0, ST_OK, 1'b0);
              6'd13: pair.r0 = make_rec(FID_FLAGS, {20'd0, acc[11:0]}, '0, ST_OK, 1'b0);
              6'd15: pair.r0 = make_rec(FID_WINDOW, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
              6'd17: pair.r0 = make_rec(FID_CKSUM, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
              default: begin
                pair.r0 = make_rec(FID_URGENT, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
                if (b_hdr <= FIXED_BYTES) begin
                  pair.two    = 1'b1;
                  pair.r1     = make_rec(FID_STATUS, '0, b_count, ST_OK, 1'b1);
                  active_next = 1'b0;
                end
              end
            endcase
          end
          6'd12: begin
            emit = 1'b1;
            header_bytes_next = {data_byte[7:4], 2'b00};
            pair.r0 = make_rec(FID_HDRLEN, {26'd0, data_byte[7:4], 2'b00}, '0, ST_OK, 1'b0);
            if (data_byte[7:4] < MIN_OFFSET) begin
              pair.two    = 1'b1;
              pair.r1     = make_rec(FID_STATUS, '0, b_count, ST_OFFSET, 1'b1);
              active_next = 1'b0;
            end
          end
          default: ;
        endcase
      end else begin
        emit = 1'b1;
        case (b_phase)
          PH_LEN: begin
            pair.r0 = make_rec(FID_OPTLEN, {24'd0, data_byte}, b_count, ST_OK, 1'b0);
            if (data_byte < min_option_len(b_kind)) begin
              err = ST_SHORT;
            end else if (data_byte > LEN_LIMIT) begin
              err = ST_TOO_LONG;
            end else begin
              option_bytes_left_next = data_byte[5:0] - 6'd2;
              option_phase_next = (data_byte[5:0] != 6'd2) ? PH_DATA : PH_KIND;
            end
          end
          PH_DATA: begin
            pair.r0 = make_rec(FID_OPTBYTE, {24'd0, data_byte}, b_count, ST_OK, 1'b0);
            option_bytes_left_next = b_left - 6'd1;
            if (b_left == 6'd1) begin
              option_phase_next = PH_KIND;
            end
          end
          default: begin
            option_count_next     = cnt_inc;
            option_kind_held_next = data_byte;
            option_phase_next     = PH_KIND;
            pair.r0 = make_rec(FID_OPTKIND, {24'd0, data_byte}, cnt_inc, ST_OK, 1'b0);
            if ((data_byte >= KIND_MSS && data_byte <= KIND_SACK) || data_byte == KIND_TSTAMP) begin
              option_phase_next = PH_LEN;
            end else if (data_byte > KIND_NOP) begin
              err = ST_BAD_KIND;
            end
          end
        endcase
        if (err != ST_OK) begin
          pair.two    = 1'b1;
          pair.r1     = make_rec(FID_STATUS, '0, option_count_next, err, 1'b1);
          active_next = 1'b0;
        end else if (pos_inc >= {1'b0, b_hdr}) begin
          pair.two    = 1'b1;
          pair.r1     = make_rec(FID_STATUS, '0, option_count_next,
                                 (option_phase_next != PH_KIND) ? ST_OVERRUN : ST_OK, 1'b1);
          active_next = 1'b0;
        end else begin
          byte_position_next = pos_inc[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      byte_position     <= '0;
      header_bytes      <= '0;
      field_accumulator <= '0;
      option_phase      <= PH_KIND;
      option_kind_held  <= '0;
      option_bytes_left <= '0;
      option_count      <= '0;
    end else begin
      active            <= active_next;
      byte_position     <= byte_position_next;
      header_bytes      <= header_bytes_next;
      field_accumulator <= field_accumulator_next;
      option_phase      <= option_phase_next;
      option_kind_held  <= option_kind_held_next;
      option_bytes_left <= option_bytes_left_next;
      option_count      <= option_count_next;
    end
  end

`ifndef SYNTHESIS
  a_second_is_status: assert property (@(posedge clk) disable iff (rst)
    emit && pair.two |-> pair.r1.field_id == FID_STATUS && pair.r1.last)
    else $error("second record is not a closing status");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    emit && pair.two |=> !active)
    else $error("still active after closing status");

  a_options_need_room: assert property (@(posedge clk) disable iff (rst)
    active && byte_position >= FIXED_BYTES |-> header_bytes > FIXED_BYTES)
    else $error("option walk without option bytes");
`endif

endmodule

[hw/rtl/thop_queue.sv]
module thop_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  thop_pkg::pair_t  din,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output thop_pkg::rec_t   dout
);
  import thop_pkg::*;

  pair_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           sel;
  logic           take, entry_done;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign valid      = (count != '0);
  assign dout       = sel ? mem[rd_ptr].r1 : mem[rd_ptr].r0;
  assign take       = valid && ready;
  assign entry_done = take && (sel || !mem[rd_ptr].two);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (entry_done) begin
        rd_ptr <= rd_ptr + 1'b1;
        sel    <= 1'b0;
      end else if (take) begin
        sel    <= 1'b1;
      end
      if (push && !entry_done) begin
        count <= count + 1'b1;
      end else if (!push && entry_done) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("write into a full queue");

  a_sel_needs_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> valid && mem[rd_ptr].two)
    else $error("second half selected without a pair");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

[hw/rtl/tcp_header_option_parser.sv]
// TCP header parser. Feed one header byte per item on the slave side, with
// s_tuser high on the first byte; that byte restarts parsing and abandons any
// header in progress without a status item. Each header yields the fixed fields
// (ports, sequence, acknowledgment, header length in bytes, twelve flag bits,
// window, checksum, urgent pointer), then for every option a kind item and,
// where present, length and data items, and closes with one status item
// carrying m_tlast. A four-entry output queue absorbs stalls; a byte is taken every
// cycle, and the slave side stalls only when that queue is full. Items pass
// through an input register and the queue to the master side; a byte gives at
// most two items, the second always the closing status, shown after the first is taken.
module tcp_header_option_parser #(
  parameter int MAX_OPTION_DATA = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // first[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // field_value[31:0], option_number[37:32], status[40:38], 0
  output logic [3:0]  m_tuser,   // field_id[3:0]
  output logic        m_tlast
);
  import thop_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       fire;
  logic       full;
  logic       emit;
  pair_t      pair;
  rec_t       head;

  assign fire     = in_valid && !full;
  assign s_tready = !in_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  thop_step #(
    .MAX_OPTION_DATA (MAX_OPTION_DATA)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (fire),
    .data_byte (in_byte),
    .first     (in_first),
    .emit      (emit),
    .pair      (pair)
  );

  thop_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fire && emit),
    .din   (pair),
    .full  (full),
    .valid (m_tvalid),
    .ready (m_tready),
    .dout  (head)
  );

  assign m_tdata = {7'd0, head.status, head.option_number, head.field_value};
  assign m_tuser = head.field_id;
  assign m_tlast = head.last;

endmodule

[verif/tcp_header_option_parser_test.sv]
module tcp_header_option_parser_test;
  import thop_pkg::*;

  localparam int OPT_DATA_MAX = 32;
  localparam int ITEMS        = 1150;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PREDICT      = -1;

  localparam logic [7:0] KIND_EOL        = 8'd0;
  localparam logic [7:0] KIND_SACK_OK    = 8'd4;
  localparam logic [7:0] KIND_UNASSIGNED = 8'd7;

  typedef struct {
    logic [7:0] b;
    logic       f;
    int         n_typed;
    rec_t       r0;
    rec_t       r1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // data_byte[7:0]
  logic        s_tuser = 1'b0;   // first[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;          // field_value[31:0], option_number[37:32], status[40:38], 0
  logic [3:0]  m_tuser;          // field_id[3:0]
  logic        m_tlast;

  rec_t      expected_fields[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        parsed_bytes = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  logic       hp_active = 1'b0;
  logic [5:0] hp_pos = '0;
  logic [5:0] hp_hdr_bytes = '0;
  logic [5:0] hp_left = '0;
  logic [5:0] hp_opt_count = '0;
  logic [31:0] hp_acc = '0;
  logic [7:0] hp_kind = '0;
  phase_t     hp_phase = PH_KIND;

  tcp_header_option_parser #(.MAX_OPTION_DATA(OPT_DATA_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  function automatic rec_t field_record(input logic [3:0] id, input logic [31:0] value,
                                        input logic [5:0] num, input logic [2:0] st,
                                        input logic lst);
    rec_t r;
    r.field_id      = id;
    r.field_value   = value;
    r.option_number = num;
    r.status        = st;
    r.last          = lst;
    return r;
  endfunction

  function automatic int option_min_len(input logic [7:0] kind);
    int len;
    len = 2;
    if (kind == KIND_MSS) len = 4;
    else if (kind == KIND_WSCALE) len = 3;
    else if (kind == KIND_TSTAMP) len = 10;
    return len;
  endfunction

  // Returns the number of records the byte yields and advances the parser state.
  function automatic int parse_header_byte(input logic [7:0] b, input logic f,
                                           output rec_t r0, output rec_t r1);
    int p;
    logic [2:0] err;
    r0 = '0;
    r1 = '0;
    err = ST_OK;
    if (f) begin
      hp_active = 1'b1;
      hp_pos = '0;
      hp_hdr_bytes = '0;
      hp_acc = '0;
      hp_phase = PH_KIND;
      hp_kind = '0;
      hp_left = '0;
      hp_opt_count = '0;
    end else if (!hp_active) begin
      return 0;
    end
    parsed_bytes++;
    p = int'(hp_pos);

    if (p < FIXED_BYTES) begin
      hp_acc = {hp_acc[23:0], b};
      hp_pos = 6'(p + 1);
      case (p)
        1:  r0 = field_record(FID_SRCPORT, {16'd0, hp_acc[15:0]}, 6'd0, ST_OK, 1'b0);
        3:  r0 = field_record(FID_DSTPORT, {16'd0, hp_acc[15:0]}, 6'd0, ST_OK, 1'b0);
        7:  r0 = field_record(FID_SEQ, hp_acc, 6'd0, ST_OK, 1'b0);
        11: r0 = field_record(FID_ACK, hp_acc, 6'd0, ST_OK, 1'b0);
        12: begin
          hp_hdr_bytes = {b[7:4], 2'b00};
          r0 = field_record(FID_HDRLEN, {26'd0, hp_hdr_bytes}, 6'd0, ST_OK, 1'b0);
        end
        13: r0 = field_record(FID_FLAGS, {20'd0, hp_acc[11:0]}, 6'd0, ST_OK, 1'b0);
        15: r0 = field_record(FID_WINDOW, {16'd0, hp_acc[15:0]}, 6'd0, ST_OK, 1'b0);
        17: r0 = field_record(FID_CKSUM, {16'd0, hp_acc[15:0]}, 6'd0, ST_OK, 1'b0);
        19: r0 = field_record(FID_URGENT, {16'd0, hp_acc[15:0]}, 6'd0, ST_OK, 1'b0);
        default: return 0;
      endcase
      if (p == 12) begin
        if (b[7:4] < MIN_OFFSET) begin
          r1 = field_record(FID_STATUS, 32'd0, hp_opt_count, ST_OFFSET, 1'b1);
          hp_active = 1'b0;
          return 2;
        end
        return 1;
      end
      hp_acc = '0;
      if (p == 19 && hp_hdr_bytes <= FIXED_BYTES) begin
        r1 = field_record(FID_STATUS, 32'd0, hp_opt_count, ST_OK, 1'b1);
        hp_active = 1'b0;
        return 2;
      end
      return 1;
    end

    case (hp_phase)
      PH_LEN: begin
        r0 = field_record(FID_OPTLEN, {24'd0, b}, hp_opt_count, ST_OK, 1'b0);
        if (b < option_min_len(hp_kind)) begin
          err = ST_SHORT;
        end else if (b - 2 > OPT_DATA_MAX) begin
          err = ST_TOO_LONG;
        end else begin
          hp_left = 6'(b - 8'd2);
          hp_phase = (hp_left != 0) ? PH_DATA : PH_KIND;
        end
      end
      PH_DATA: begin
        r0 = field_record(FID_OPTBYTE, {24'd0, b}, hp_opt_count, ST_OK, 1'b0);
        hp_left = hp_left - 6'd1;
        if (hp_left == 0) hp_phase = PH_KIND;
      end
      default: begin
        hp_opt_count = hp_opt_count + 6'd1;
        hp_kind = b;
        hp_phase = PH_KIND;
        r0 = field_record(FID_OPTKIND, {24'd0, b}, hp_opt_count, ST_OK, 1'b0);
        if ((b >= KIND_MSS && b <= KIND_SACK) || b == KIND_TSTAMP) hp_phase = PH_LEN;
        else if (b > KIND_NOP) err = ST_BAD_KIND;
      end
    endcase

    if (err != ST_OK) begin
      r1 = field_record(FID_STATUS, 32'd0, hp_opt_count, err, 1'b1);
      hp_active = 1'b0;
      return 2;
    end
    if (p + 1 >= hp_hdr_bytes) begin
      r1 = field_record(FID_STATUS, 32'd0, hp_opt_count,
                        (hp_phase != PH_KIND) ? ST_OVERRUN : ST_OK, 1'b1);
      hp_active = 1'b0;
      return 2;
    end
    hp_pos = 6'(p + 1);
    return 1;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_item(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Typed records, where given, replace the predicted ones; the parser state still advances.
  task automatic feed(input logic [7:0] b, input logic f, input int n_typed,
                      input rec_t t0, input rec_t t1);
    rec_t r0, r1;
    int n;
    send_item(b, f);
    n = parse_header_byte(b, f, r0, r1);
    if (n_typed != PREDICT) begin
      n = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) expected_fields.push_back(r0);
    if (n > 1) expected_fields.push_back(r1);
  endtask

  task automatic add_row(input logic [7:0] b, input logic f, input int n_typed,
                         input rec_t r0, input rec_t r1);
    stim_row_t row;
    row.b = b;
    row.f = f;
    row.n_typed = n_typed;
    row.r0 = r0;
    row.r1 = r1;
    directed_rows.push_back(row);
  endtask

  task automatic send_header();
    logic [7:0] hdr[$];
    logic [7:0] rnd;
    logic [3:0] offset;
    int hlen, pick, kind, len, min_len, cut;
    pick = $urandom_range(0, 19);
    if (pick < 2) offset = 4'($urandom_range(0, 4));
    else if (pick < 5) offset = MIN_OFFSET;
    else offset = 4'($urandom_range(6, 15));

    for (int i = 0; i < FIXED_BYTES; i++) begin
      rnd = 8'($urandom);
      pick = $urandom_range(0, 7);
      if (i == 12) rnd[7:4] = offset;
      else if (pick == 0) rnd = 8'hFF;
      else if (pick == 1) rnd = 8'h00;
      hdr.push_back(rnd);
    end

    hlen = offset * 4;
    while (hdr.size() < hlen) begin
      pick = $urandom_range(0, 99);
      len = -1;
      case ($urandom_range(0, 4))
        0: kind = int'(KIND_MSS);
        1: kind = int'(KIND_WSCALE);
        2: kind = int'(KIND_SACK_OK);
        3: kind = int'(KIND_SACK);
        default: kind = int'(KIND_TSTAMP);
      endcase
      min_len = option_min_len(8'(kind));
      if (pick < 12) begin
        kind = $urandom_range(0, 1) ? int'(KIND_NOP) : int'(KIND_EOL);
      end else if (pick < 80) begin
        if (kind == KIND_SACK) len = 2 + 8 * $urandom_range(0, 4);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(min_len, 2 + OPT_DATA_MAX);
        else len = min_len;
      end else if (pick < 86) begin
        if ($urandom_range(0, 2) == 0) kind = $urandom_range(0, 1) ? int'(KIND_UNASSIGNED) - 1
                                                                   : int'(KIND_UNASSIGNED);
        else kind = $urandom_range(KIND_TSTAMP + 1, 255);
      end else if (pick < 92) begin
        len = $urandom_range(0, min_len - 1);
      end else if (pick < 97) begin
        len = $urandom_range(0, 1) ? 3 + OPT_DATA_MAX : $urandom_range(3 + OPT_DATA_MAX, 255);
      end else begin
        kind = $urandom_range(0, 255);
        len = $urandom_range(0, 255);
      end
      hdr.push_back(kind[7:0]);
      if (len >= 0) begin
        hdr.push_back(len[7:0]);
        for (int i = 2; i < len && i < 2 + OPT_DATA_MAX; i++) begin
          rnd = 8'($urandom);
          hdr.push_back(rnd);
        end
      end
    end
    while (hdr.size() > FIXED_BYTES && hdr.size() > hlen) hdr.pop_back();

    // abandon the header part way through; the next header restarts the parser
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, hdr.size() - 1);
      while (hdr.size() > cut) hdr.pop_back();
    end

    for (int i = 0; i < hdr.size(); i++) feed(hdr[i], i == 0, PREDICT, '0, '0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        rnd = 8'($urandom);
        feed(rnd, 1'b0, PREDICT, '0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_output
    rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fields.size() == 0) begin
        note_mismatch("item with nothing expected, field_value", m_tdata[31:0], 32'd0);
      end else begin
        want = expected_fields.pop_front();
        if (m_tuser !== want.field_id)
          note_mismatch("field_id", 32'(m_tuser), 32'(want.field_id));
        if (m_tdata[31:0] !== want.field_value)
          note_mismatch("field_value", m_tdata[31:0], want.field_value);
        if (m_tdata[37:32] !== want.option_number)
          note_mismatch("option_number", 32'(m_tdata[37:32]), 32'(want.option_number));
        if (m_tdata[40:38] !== want.status)
          note_mismatch("status", 32'(m_tdata[40:38]), 32'(want.status));
        if (m_tlast !== want.last) note_mismatch("last", 32'(m_tlast), 32'(want.last));
        if (m_tdata[47:41] !== 7'd0)
          note_mismatch("tdata padding", 32'(m_tdata[47:41]), 32'd0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tcp_header_option_parser_test failed");
        $finish;
      end
    end
  end

  initial begin
    int base;
    // idle byte, restarted header, then a full header ending on an unassigned kind
    add_row(8'h5A, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b1, 0, '0, '0);
    add_row(8'h01, 1'b0, 1, field_record(FID_SRCPORT, 32'h0001, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h80, 1'b0, PREDICT, '0, '0);
    add_row(8'hFF, 1'b1, 0, '0, '0);
    add_row(8'hFF, 1'b0, 1, field_record(FID_SRCPORT, 32'hFFFF, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 1, field_record(FID_DSTPORT, 32'h0, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b0, 1, field_record(FID_SEQ, 32'hFFFF_FFFF, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 1, field_record(FID_ACK, 32'h0, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h6F, 1'b0, 1, field_record(FID_HDRLEN, 32'd24, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'hFF, 1'b0, 1, field_record(FID_FLAGS, 32'hFFF, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 1, field_record(FID_WINDOW, 32'h0, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'h12, 1'b0, 0, '0, '0);
    add_row(8'h34, 1'b0, 1, field_record(FID_CKSUM, 32'h1234, 6'd0, ST_OK, 1'b0), '0);
    add_row(8'hAB, 1'b0, 0, '0, '0);
    add_row(8'hCD, 1'b0, 1, field_record(FID_URGENT, 32'hABCD, 6'd0, ST_OK, 1'b0), '0);
    add_row(KIND_NOP, 1'b0, 1,
            field_record(FID_OPTKIND, {24'd0, KIND_NOP}, 6'd1, ST_OK, 1'b0), '0);
    add_row(KIND_EOL, 1'b0, 1,
            field_record(FID_OPTKIND, {24'd0, KIND_EOL}, 6'd2, ST_OK, 1'b0), '0);
    add_row(KIND_UNASSIGNED, 1'b0, 2,
            field_record(FID_OPTKIND, {24'd0, KIND_UNASSIGNED}, 6'd3, ST_OK, 1'b0),
            field_record(FID_STATUS, 32'd0, 6'd3, ST_BAD_KIND, 1'b1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      feed(directed_rows[i].b, directed_rows[i].f, directed_rows[i].n_typed,
           directed_rows[i].r0, directed_rows[i].r1);

    base = parsed_bytes;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      while (parsed_bytes < base + (ph + 1) * (ITEMS - base) / 4) send_header();
    end
    s_tvalid <= 1'b0;

    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tcp_header_option_parser_test passed");
    end else begin
      $display("tcp_header_option_parser_test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/thop_pkg.sv
hw/rtl/thop_step.sv
hw/rtl/thop_queue.sv
hw/rtl/tcp_header_option_parser.sv
verif/tcp_header_option_parser_test.sv
